/* src/vts_pkg.sv */
// Shared types, constants and the blend function of the volume trilinear sampler.
package vts_pkg;

   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = 24;
   localparam int CRD_W     = 18;
   localparam int N_W       = 6;
   localparam int ZY_W      = 12;
   localparam int IDX_W     = 18;
   localparam int CNT_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int POS_W     = FRAC_BITS + 1 + N_W;
   localparam int NCORNER   = 8;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SIZE_X = 3'd0,
      REG_SIZE_Y = 3'd1,
      REG_SIZE_Z = 3'd2,
      REG_COUNT  = 3'd3
   } reg_idx_type;

   typedef struct packed {
      logic [N_W-1:0]   nx;
      logic [N_W-1:0]   ny;
      logic [N_W-1:0]   nz;
      logic [CNT_W-1:0] cnt;
      logic             empty;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic                 empty;
      logic [NCORNER-1:0]   ok;
      logic [FRAC_BITS-1:0] tx;
      logic [FRAC_BITS-1:0] ty;
      logic [FRAC_BITS-1:0] tz;
   } smp_type;

   function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b,
                                              input logic [FRAC_BITS-1:0] t);
      logic                       up;
      logic [VAL_W-1:0]           d;
      logic [VAL_W+FRAC_BITS-1:0] p;
      up = (b >= a);
      d  = up ? (b - a) : (a - b);
      p  = (VAL_W+FRAC_BITS)'(d) * (VAL_W+FRAC_BITS)'(t);
      return up ? (a + p[VAL_W+FRAC_BITS-1:FRAC_BITS]) : (a - p[VAL_W+FRAC_BITS-1:FRAC_BITS]);
   endfunction

endpackage

/* src/volume_trilinear_sampler.sv */
// Top level of the volume trilinear sampler: config registers, voxel RAM copies, pipeline.
//
//  channel | direction | beat contents
//  req_    | in        | tuser: operation; tdata: voxel_index, voxel_value, u, v, w
//  rsp_    | out       | tdata: sample_value (one beat per sample beat)
//  csr_    | in        | index, data; always ready
//
// One beat per cycle in while not stalled; a sample result passes the scale, index,
// corner-read, x-blend, y-blend and result registers. Eight RAM copies give all eight
// corners in one read; a write beat passes s1 and s2 to every copy, in order with samples.
// Reset clears control state only; the voxel RAM needs no clearing pass.
// A stalled result blocks intake once the stage behind it also holds a sample.
module volume_trilinear_sampler import vts_pkg::*; #(
   parameter int MAX_RES    = 32,
   parameter int MAX_VOXELS = 32768
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [95:0]          req_tdata,  // voxel_index, voxel_value, coord_u, coord_v, coord_w
   input  logic                 req_tuser,  // operation
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,  // sample_value
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   localparam int AW = $clog2(MAX_VOXELS);

   logic [N_W-1:0]   size_x_ff, size_y_ff, size_z_ff;
   logic [CNT_W-1:0] count_ff;
   cfg_type          cfg;
   logic             adv;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [VAL_W-1:0] wr_data;
   logic [AW-1:0]    rd_addr [NCORNER];
   logic [VAL_W-1:0] corner [NCORNER];
   smp_type          smp;

   assign csr_ready  = 1'b1;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= '0;
         size_y_ff <= '0;
         size_z_ff <= '0;
         count_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SIZE_X: size_x_ff <= csr_data[N_W-1:0];
            REG_SIZE_Y: size_y_ff <= csr_data[N_W-1:0];
            REG_SIZE_Z: size_z_ff <= csr_data[N_W-1:0];
            REG_COUNT:  count_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.nx  = (32'(size_x_ff) > 32'(MAX_RES)) ? N_W'(MAX_RES) : size_x_ff;
      cfg.ny  = (32'(size_y_ff) > 32'(MAX_RES)) ? N_W'(MAX_RES) : size_y_ff;
      cfg.nz  = (32'(size_z_ff) > 32'(MAX_RES)) ? N_W'(MAX_RES) : size_z_ff;
      cfg.cnt = (32'(count_ff) > 32'(MAX_VOXELS)) ? CNT_W'(MAX_VOXELS) : count_ff;
      cfg.empty = (cfg.cnt == '0) || (cfg.nx == '0) || (cfg.ny == '0) || (cfg.nz == '0);
   end

   vts_addr #(.MAX_VOXELS(MAX_VOXELS), .AW(AW)) u_addr (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid),
      .in_op    (req_tuser),
      .in_index (req_tdata[14:0]),
      .in_value (req_tdata[38:15]),
      .in_u     (req_tdata[56:39]),
      .in_v     (req_tdata[74:57]),
      .in_w     (req_tdata[92:75]),
      .cfg      (cfg),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .smp_ff   (smp)
   );

   for (genvar k = 0; k < NCORNER; k++) begin : g_ram
      vts_ram #(.WIDTH(VAL_W), .DEPTH(MAX_VOXELS)) u_ram (
         .clock      (clock),
         .wr_en      (wr_en),
         .wr_addr    (wr_addr),
         .wr_data    (wr_data),
         .rd_en      (adv),
         .rd_addr    (rd_addr[k]),
         .rd_data_ff (corner[k])
      );
   end

   vts_blend u_blend (
      .clock        (clock),
      .reset        (reset),
      .smp          (smp),
      .corner       (corner),
      .out_ready    (rsp_tready),
      .adv          (adv),
      .out_valid_ff (rsp_tvalid),
      .out_data_ff  (rsp_tdata)
   );

endmodule

/* src/vts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module vts_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

/* src/vts_addr.sv */
// Coordinate clamp and scale, corner index generation, voxel write issue.
module vts_addr import vts_pkg::*; #(
   parameter int MAX_VOXELS = 32768,
   parameter int AW         = 15
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic                 in_op,
   input  logic [14:0]          in_index,
   input  logic [VAL_W-1:0]     in_value,
   input  logic [CRD_W-1:0]     in_u,
   input  logic [CRD_W-1:0]     in_v,
   input  logic [CRD_W-1:0]     in_w,
   input  cfg_type              cfg,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output logic [VAL_W-1:0]     wr_data,
   output logic [AW-1:0]        rd_addr [NCORNER],
   output smp_type              smp_ff
);

   logic                 s1_valid_ff, s1_write_ff, s1_empty_ff;
   logic [14:0]          s1_index_ff;
   logic [VAL_W-1:0]     s1_value_ff;
   logic [POS_W-1:0]     s1_px_ff, s1_py_ff, s1_pz_ff;

   logic                 s2_valid_ff, s2_write_ff, s2_empty_ff;
   logic [14:0]          s2_index_ff;
   logic [VAL_W-1:0]     s2_value_ff;
   logic [N_W-1:0]       s2_x_ff [2];
   logic [ZY_W-1:0]      s2_zy_ff [4];
   logic [FRAC_BITS-1:0] s2_tx_ff, s2_ty_ff, s2_tz_ff;

   logic [FRAC_BITS:0]   cu, cv, cw;
   logic [N_W-1:0]       nxm1, nym1, nzm1;
   logic [N_W-1:0]       x0, y0, z0, x1, y1, z1;
   logic [N_W-1:0]       yy [2];
   logic [N_W-1:0]       zz [2];
   logic [ZY_W-1:0]      zy_in [4];
   logic [IDX_W-1:0]     idx [NCORNER];
   logic [31:0]          idx32 [NCORNER];
   logic [31:0]          widx32;
   smp_type              smp_in;

   function automatic logic [FRAC_BITS:0] clamp(input logic [CRD_W-1:0] c);
      if (c[CRD_W-1]) begin
         return '0;
      end
      if (c[CRD_W-2:0] > (CRD_W-1)'(1 << FRAC_BITS)) begin
         return (FRAC_BITS+1)'(1 << FRAC_BITS);
      end
      return c[FRAC_BITS:0];
   endfunction

   assign nxm1 = cfg.nx - 1'b1;
   assign nym1 = cfg.ny - 1'b1;
   assign nzm1 = cfg.nz - 1'b1;
   assign cu = clamp(in_u);
   assign cv = clamp(in_v);
   assign cw = clamp(in_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         smp_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         smp_ff.valid <= smp_in.valid;
      end
      if (adv) begin
         s1_write_ff <= (op_type'(in_op) == OP_WRITE);
         s1_empty_ff <= cfg.empty;
         s1_index_ff <= in_index;
         s1_value_ff <= in_value;
         s1_px_ff    <= POS_W'(cu) * POS_W'(nxm1);
         s1_py_ff    <= POS_W'(cv) * POS_W'(nym1);
         s1_pz_ff    <= POS_W'(cw) * POS_W'(nzm1);
         s2_write_ff <= s1_write_ff;
         s2_empty_ff <= s1_empty_ff;
         s2_index_ff <= s1_index_ff;
         s2_value_ff <= s1_value_ff;
         s2_x_ff[0]  <= x0;
         s2_x_ff[1]  <= x1;
         s2_zy_ff    <= zy_in;
         s2_tx_ff    <= s1_px_ff[FRAC_BITS-1:0];
         s2_ty_ff    <= s1_py_ff[FRAC_BITS-1:0];
         s2_tz_ff    <= s1_pz_ff[FRAC_BITS-1:0];
         smp_ff.empty <= smp_in.empty;
         smp_ff.ok    <= smp_in.ok;
         smp_ff.tx    <= smp_in.tx;
         smp_ff.ty    <= smp_in.ty;
         smp_ff.tz    <= smp_in.tz;
      end
   end

   always_comb begin
      x0 = s1_px_ff[FRAC_BITS+N_W-1:FRAC_BITS];
      y0 = s1_py_ff[FRAC_BITS+N_W-1:FRAC_BITS];
      z0 = s1_pz_ff[FRAC_BITS+N_W-1:FRAC_BITS];
      x1 = ((x0 + 1'b1) < nxm1) ? (x0 + 1'b1) : nxm1;
      y1 = ((y0 + 1'b1) < nym1) ? (y0 + 1'b1) : nym1;
      z1 = ((z0 + 1'b1) < nzm1) ? (z0 + 1'b1) : nzm1;
      yy[0] = y0;
      yy[1] = y1;
      zz[0] = z0;
      zz[1] = z1;
      for (int j = 0; j < 4; j++) begin
         zy_in[j] = ZY_W'(zz[j>>1]) * ZY_W'(cfg.ny) + ZY_W'(yy[j&1]);
      end
   end

   always_comb begin
      smp_in.valid = s2_valid_ff && !s2_write_ff;
      smp_in.empty = s2_empty_ff;
      smp_in.tx    = s2_tx_ff;
      smp_in.ty    = s2_ty_ff;
      smp_in.tz    = s2_tz_ff;
      for (int k = 0; k < NCORNER; k++) begin
         idx[k]   = IDX_W'(s2_zy_ff[k>>1]) * IDX_W'(cfg.nx) + IDX_W'(s2_x_ff[k&1]);
         idx32[k] = 32'(idx[k]);
         smp_in.ok[k] = (idx32[k] < 32'(MAX_VOXELS)) && (idx[k] < IDX_W'(cfg.cnt));
         rd_addr[k]   = idx32[k][AW-1:0];
      end
      widx32  = 32'(s2_index_ff);
      wr_en   = adv && s2_valid_ff && s2_write_ff && (widx32 < 32'(MAX_VOXELS));
      wr_addr = widx32[AW-1:0];
      wr_data = s2_value_ff;
   end

endmodule

/* src/vts_blend.sv */
// Trilinear blend pipeline (x, y, z) and result register.
module vts_blend import vts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  smp_type          smp,
   input  logic [VAL_W-1:0] corner [NCORNER],
   input  logic             out_ready,
   output logic             adv,
   output logic             out_valid_ff,
   output logic [VAL_W-1:0] out_data_ff
);

   logic                 s4_valid_ff, s4_empty_ff;
   logic [VAL_W-1:0]     s4_c_ff [4];
   logic [FRAC_BITS-1:0] s4_ty_ff, s4_tz_ff;
   logic                 s5_valid_ff, s5_empty_ff;
   logic [VAL_W-1:0]     s5_c_ff [2];
   logic [FRAC_BITS-1:0] s5_tz_ff;
   logic [VAL_W-1:0]     v [NCORNER];
   logic [VAL_W-1:0]     c4_in [4];
   logic [VAL_W-1:0]     res;
   logic                 out_load;

   assign out_load = !out_valid_ff || out_ready;
   assign adv      = out_load || !s5_valid_ff;

   always_comb begin
      for (int k = 0; k < NCORNER; k++) begin
         v[k] = smp.ok[k] ? corner[k] : '0;
      end
      for (int j = 0; j < 4; j++) begin
         c4_in[j] = blend(v[2*j], v[2*j+1], smp.tx);
      end
      res = s5_empty_ff ? '0 : blend(s5_c_ff[0], s5_c_ff[1], s5_tz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s4_valid_ff <= smp.valid;
            s5_valid_ff <= s4_valid_ff;
         end
         if (out_load) begin
            out_valid_ff <= s5_valid_ff;
         end
      end
      if (adv) begin
         s4_empty_ff <= smp.empty;
         s4_c_ff     <= c4_in;
         s4_ty_ff    <= smp.ty;
         s4_tz_ff    <= smp.tz;
         s5_empty_ff <= s4_empty_ff;
         s5_c_ff[0]  <= blend(s4_c_ff[0], s4_c_ff[1], s4_ty_ff);
         s5_c_ff[1]  <= blend(s4_c_ff[2], s4_c_ff[3], s4_ty_ff);
         s5_tz_ff    <= s4_tz_ff;
      end
      if (out_load) begin
         out_data_ff <= res;
      end
   end

endmodule

/* src/vts_checker.sv */
// Port-level checker for the volume trilinear sampler, bound to the top level.
module vts_checker import vts_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [23:0]          rsp_tdata,
   input logic                 csr_valid,
   input logic                 csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("intake stalled without a blocked result");

   a_csr_ready: assert property (@(posedge clock)
      csr_valid |-> csr_ready)
      else $error("csr write refused");

endmodule

bind volume_trilinear_sampler vts_checker u_vts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
